### rtl/hts_pkg.sv
// Shared types, constants and templates for the hex to tetrahedra splitter.
package hts_pkg;

  localparam int ID_BITS_DEF = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_TETS = 6;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_TWO   = 2'd2,
    KIND_THREE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] face;
  } hex_cls_t;

  typedef logic [2:0] vidx_t;

  localparam vidx_t TPL [4][MAX_TETS][4] = '{
    '{'{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd2, 3'd7, 3'd5}, '{3'd0, 3'd2, 3'd3, 3'd7},
      '{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd2, 3'd7, 3'd5, 3'd6}, '{3'd0, 3'd0, 3'd0, 3'd0}},
    '{'{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd0, 3'd1, 3'd7, 3'd5}, '{3'd1, 3'd6, 3'd7, 3'd5},
      '{3'd0, 3'd7, 3'd2, 3'd3}, '{3'd0, 3'd7, 3'd1, 3'd2}, '{3'd1, 3'd7, 3'd6, 3'd2}},
    '{'{3'd0, 3'd4, 3'd5, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
      '{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd3, 3'd6, 3'd2}, '{3'd0, 3'd6, 3'd5, 3'd2}},
    '{'{3'd0, 3'd2, 3'd3, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
      '{3'd0, 3'd5, 3'd6, 3'd4}, '{3'd1, 3'd5, 3'd6, 3'd0}, '{3'd1, 3'd6, 3'd2, 3'd0}}
  };

  localparam vidx_t FLIP_SWAPS [4][2] = '{
    '{3'd0, 3'd4}, '{3'd3, 3'd5}, '{3'd1, 3'd7}, '{3'd2, 3'd6}
  };

  localparam vidx_t FAR_FACES [3][4] = '{
    '{3'd6, 3'd5, 3'd1, 3'd2}, '{3'd6, 3'd2, 3'd3, 3'd7}, '{3'd6, 3'd7, 3'd4, 3'd5}
  };

  localparam vidx_t AXIS_RING [6] = '{3'd1, 3'd2, 3'd3, 3'd7, 3'd5, 3'd4};

endpackage

### rtl/hts_front.sv
// Front pipeline: finds the minimum corner, orients the hex and classifies its far corner.
module hts_front #(
  parameter int ID_BITS = hts_pkg::ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ID_BITS-1:0]        corner_0,
  input  logic [ID_BITS-1:0]        corner_1,
  input  logic [ID_BITS-1:0]        corner_2,
  input  logic [ID_BITS-1:0]        corner_3,
  input  logic [ID_BITS-1:0]        corner_4,
  input  logic [ID_BITS-1:0]        corner_5,
  input  logic [ID_BITS-1:0]        corner_6,
  input  logic [ID_BITS-1:0]        corner_7,
  output logic                      push_valid,
  input  logic                      push_stall,
  output logic [7:0][ID_BITS-1:0]   push_hex,
  output hts_pkg::hex_cls_t         push_cls
);
  import hts_pkg::*;

  function automatic logic [ID_BITS-1:0] min_id(input logic [ID_BITS-1:0] a,
                                                 input logic [ID_BITS-1:0] b);
    min_id = (a < b) ? a : b;
  endfunction

  logic                    v1, v2, v3, v4;
  logic                    adv1, adv2, adv3, adv4;
  logic [7:0][ID_BITS-1:0] s1_c, s2_c, s3_h, s4_h;
  logic [3:0]              s1_lt;
  logic [2:0]              s2_mi;
  hex_cls_t                s4_cls;

  logic [7:0][ID_BITS-1:0] in_c;
  logic [3:0]              lt_next;
  logic [2:0]              mi_next;
  logic [7:0][ID_BITS-1:0] h_next;
  hex_cls_t                cls_next;

  assign adv4 = !v4 || !push_stall;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  assign in_c = {corner_7, corner_6, corner_5, corner_4,
                 corner_3, corner_2, corner_1, corner_0};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lt_next[k] = in_c[2*k+1] < in_c[2*k];
    end
  end

  always_comb begin
    logic [3:0][2:0] w;
    logic [2:0]      m0, m1;
    for (int k = 0; k < 4; k++) begin
      w[k] = {2'(k), s1_lt[k]};
    end
    m0 = (s1_c[w[1]] < s1_c[w[0]]) ? w[1] : w[0];
    m1 = (s1_c[w[3]] < s1_c[w[2]]) ? w[3] : w[2];
    mi_next = (s1_c[m1] < s1_c[m0]) ? m1 : m0;
  end

  always_comb begin
    logic [7:0][ID_BITS-1:0] h;
    logic [1:0]              r;
    for (int i = 0; i < 4; i++) begin
      r = 2'(i) + s2_mi[1:0];
      h[i]     = s2_c[{1'b0, r}];
      h[4 + i] = s2_c[{1'b1, r}];
    end
    h_next = h;
    if (s2_mi[2]) begin
      for (int i = 0; i < 4; i++) begin
        h_next[FLIP_SWAPS[i][0]] = h[FLIP_SWAPS[i][1]];
        h_next[FLIP_SWAPS[i][1]] = h[FLIP_SWAPS[i][0]];
      end
    end
  end

  always_comb begin
    logic [2:0] into;
    logic [1:0] cnt;
    logic [1:0] face;
    for (int i = 0; i < 3; i++) begin
      into[i] = min_id(s3_h[FAR_FACES[i][0]], s3_h[FAR_FACES[i][2]]) <
                min_id(s3_h[FAR_FACES[i][1]], s3_h[FAR_FACES[i][3]]);
    end
    cnt = {1'b0, into[0]} + {1'b0, into[1]} + {1'b0, into[2]};
    face = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if ((cnt == 2'd1 && into[i]) || (cnt == 2'd2 && !into[i])) begin
        face = 2'(i);
      end
    end
    cls_next.kind = kind_t'(cnt);
    cls_next.face = face;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_c  <= in_c;
      s1_lt <= lt_next;
    end
    if (adv2) begin
      s2_c  <= s1_c;
      s2_mi <= mi_next;
    end
    if (adv3) begin
      s3_h <= h_next;
    end
    if (adv4) begin
      s4_h   <= s3_h;
      s4_cls <= cls_next;
    end
  end

  assign push_valid = v4;
  assign push_hex   = s4_h;
  assign push_cls   = s4_cls;

endmodule

### rtl/hts_queue.sv
// Short queue of classified hexes between the front pipeline and the emitter.
module hts_queue #(
  parameter int ID_BITS = hts_pkg::ID_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  output logic                    push_stall,
  input  logic [7:0][ID_BITS-1:0] push_hex,
  input  hts_pkg::hex_cls_t       push_cls,
  output logic                    pop_valid,
  input  logic                    pop_stall,
  output logic [7:0][ID_BITS-1:0] pop_hex,
  output hts_pkg::hex_cls_t       pop_cls
);
  import hts_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [7:0][ID_BITS-1:0] q_hex [QUEUE_DEPTH];
  hex_cls_t                q_cls [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr, rd_ptr;
  logic [CNT_W-1:0]        count;
  logic                    push, pop;

  assign push_stall = count == FULL;
  assign pop_valid  = count != '0;
  assign push = push_valid && !push_stall;
  assign pop  = pop_valid && !pop_stall;
  assign pop_hex = q_hex[rd_ptr];
  assign pop_cls = q_cls[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_hex[wr_ptr] <= push_hex;
      q_cls[wr_ptr] <= push_cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("Queue count exceeds its depth.");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    push_stall |-> count == FULL)
    else $error("Queue stalls while it has room.");
  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("Queue count did not drop after a pop.");

endmodule

### rtl/hts_back.sv
// Emitter: turns the axis ring and streams the tetrahedra of one hex per template.
module hts_back #(
  parameter int ID_BITS = hts_pkg::ID_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  output logic                    pop_stall,
  input  logic [7:0][ID_BITS-1:0] pop_hex,
  input  hts_pkg::hex_cls_t       pop_cls,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ID_BITS-1:0]      tet_vert_a,
  output logic [ID_BITS-1:0]      tet_vert_b,
  output logic [ID_BITS-1:0]      tet_vert_c,
  output logic [ID_BITS-1:0]      tet_vert_d,
  output logic                    last_tet
);
  import hts_pkg::*;

  logic                    cur_valid;
  logic [7:0][ID_BITS-1:0] cur_hex;
  kind_t                   cur_kind;
  logic [2:0]              cur_idx;
  logic [2:0]              tet_n;
  logic                    load, is_last, take;
  logic [7:0][ID_BITS-1:0] turned;

  assign tet_n   = (cur_kind == KIND_NONE) ? 3'd5 : 3'd6;
  assign is_last = cur_idx == tet_n - 3'd1;
  assign load    = cur_valid && (!out_valid || !out_stall);
  assign take    = !cur_valid || (load && is_last);
  assign pop_stall = !take;

  always_comb begin
    logic [5:0][ID_BITS-1:0] old;
    logic [2:0]              shift;
    logic [3:0]              src;
    for (int i = 0; i < 6; i++) begin
      old[i] = pop_hex[AXIS_RING[i]];
    end
    case (pop_cls.face)
      2'd1:    shift = 3'd4;
      2'd2:    shift = 3'd2;
      default: shift = 3'd0;
    endcase
    if (!(pop_cls.kind inside {KIND_ONE, KIND_TWO})) begin
      shift = 3'd0;
    end
    turned = pop_hex;
    for (int i = 0; i < 6; i++) begin
      src = 4'(i + 6) - {1'b0, shift};
      if (src >= 4'd6) src = src - 4'd6;
      turned[AXIS_RING[i]] = old[src[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_idx   <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        cur_valid <= pop_valid;
        cur_idx   <= 3'd0;
      end else if (load) begin
        cur_idx <= cur_idx + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && pop_valid) begin
      cur_hex  <= turned;
      cur_kind <= pop_cls.kind;
    end
    if (load) begin
      tet_vert_a <= cur_hex[TPL[cur_kind][cur_idx][0]];
      tet_vert_b <= cur_hex[TPL[cur_kind][cur_idx][1]];
      tet_vert_c <= cur_hex[TPL[cur_kind][cur_idx][2]];
      tet_vert_d <= cur_hex[TPL[cur_kind][cur_idx][3]];
      last_tet   <= is_last;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur_idx < tet_n)
    else $error("Tetrahedron index runs past the template.");
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    (load && cur_idx == 3'd0) |=> !last_tet)
    else $error("First tetrahedron of a hex is marked last.");
  a_take_on_last: assert property (@(posedge clk) disable iff (rst)
    (load && is_last && !pop_valid) |=> !cur_valid)
    else $error("Emitter kept a finished hex.");

endmodule

### rtl/hex_to_tet_split_core.sv
// Top level of the hex to tetrahedra splitter: front pipeline, queue and emitter.
// Input channel: in_valid/in_stall carries one hexahedron as eight corner ids,
// corner_0..corner_3 the lower quad and corner_4..corner_7 the upper quad.
// A transaction completes on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carries one tetrahedron per transaction as
// four vertex ids, with last_tet set on the final tetrahedron of each hex.
// A hex yields five tetrahedra when no far-corner diagonal enters corner six,
// and six otherwise, one per cycle from the emitter's output register while out_stall is low.
// With both sides idle the first tetrahedron passes through the front stages, one
// queue slot, the emitter's hex register and its output register. The emitter takes
// the next hex as it loads the last tetrahedron of the current one and sends one
// tetrahedron per cycle while the receiver does not stall; the front pipeline can
// take a hex in every cycle while in_stall is low.
// When the receiver stalls, the output holds, the emitter waits, and the queue
// and front stages fill before in_stall rises.
// Synchronous reset empties the pipeline, the queue and the output register.
module hex_to_tet_split_core #(
  parameter int ID_BITS = hts_pkg::ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_BITS-1:0] corner_0,
  input  logic [ID_BITS-1:0] corner_1,
  input  logic [ID_BITS-1:0] corner_2,
  input  logic [ID_BITS-1:0] corner_3,
  input  logic [ID_BITS-1:0] corner_4,
  input  logic [ID_BITS-1:0] corner_5,
  input  logic [ID_BITS-1:0] corner_6,
  input  logic [ID_BITS-1:0] corner_7,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_BITS-1:0] tet_vert_a,
  output logic [ID_BITS-1:0] tet_vert_b,
  output logic [ID_BITS-1:0] tet_vert_c,
  output logic [ID_BITS-1:0] tet_vert_d,
  output logic               last_tet
);
  import hts_pkg::*;

  logic                    push_valid, push_stall;
  logic [7:0][ID_BITS-1:0] push_hex;
  hex_cls_t                push_cls;
  logic                    pop_valid, pop_stall;
  logic [7:0][ID_BITS-1:0] pop_hex;
  hex_cls_t                pop_cls;

  hts_front #(.ID_BITS(ID_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .corner_0   (corner_0),
    .corner_1   (corner_1),
    .corner_2   (corner_2),
    .corner_3   (corner_3),
    .corner_4   (corner_4),
    .corner_5   (corner_5),
    .corner_6   (corner_6),
    .corner_7   (corner_7),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_hex   (push_hex),
    .push_cls   (push_cls)
  );

  hts_queue #(.ID_BITS(ID_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_hex   (push_hex),
    .push_cls   (push_cls),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_hex    (pop_hex),
    .pop_cls    (pop_cls)
  );

  hts_back #(.ID_BITS(ID_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_hex    (pop_hex),
    .pop_cls    (pop_cls),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tet_vert_a (tet_vert_a),
    .tet_vert_b (tet_vert_b),
    .tet_vert_c (tet_vert_c),
    .tet_vert_d (tet_vert_d),
    .last_tet   (last_tet)
  );

endmodule
